/* rtl/core/v4n_pkg.sv */
// Shared constants and word types for the four-component vector normalizer.
`timescale 1ns / 1ps
package v4n_pkg;

	localparam int NUM_COMP      = 4;
	localparam int COMP_W        = 32;
	localparam int OUT_FRAC_BITS = 30;
	localparam int LEN_W         = COMP_W + 1;
	localparam int SQ_W          = 2 * COMP_W;
	localparam int SUM_W         = 2 * LEN_W;
	localparam int QUO_W         = OUT_FRAC_BITS + 1;
	localparam int UNIT_W        = 32;

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_x;
		logic signed [COMP_W-1:0] comp_y;
		logic signed [COMP_W-1:0] comp_z;
		logic signed [COMP_W-1:0] comp_e;
	} in_word_t;

	typedef struct packed {
		logic [LEN_W-1:0]         vec_length;
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic signed [UNIT_W-1:0] unit_e;
		logic                     zero_length;
	} out_word_t;

endpackage

/* rtl/core/vector4_length_normalize_core.sv */
// Top level: pipelined Euclidean length and unit vector of a four-component vector.
`timescale 1ns / 1ps
// Usage notes
// - Input channel vec_*: one word holds x, y, z, e components in signed Q15.16.
//   A word is taken at a clock edge with vec_valid high and vec_stall low.
// - Output channel norm_*: one word per input word, in order: length (Q17.16,
//   truncated root) and the four unit components in signed Q1.30, truncated
//   toward zero. A zero vector sets zero_length and gives zero components.
// - Pipeline: magnitude, square, pair-sum and full-sum stages, then the square
//   root stages (one root bit per stage), the stages of the four dividers (one
//   quotient bit per stage) and one output register.
// - Throughput: one word per cycle unless norm_stall holds the output word. Every
//   stage is a register slice; the whole pipe moves together with one shared enable.
// - When the receiver holds norm_stall with a word on the output, the pipe
//   freezes and vec_stall rises in the same cycle; nothing is lost or
//   repeated. Bubbles move forward only while the pipe advances.
// - Reset (arst_n low) clears all stage valid bits at once; payload registers
//   are not reset. The block keeps no state between words.
module vector4_length_normalize_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_stall,
	input  v4n_pkg::in_word_t  vec_word,
	output logic               norm_valid,
	input  logic               norm_stall,
	output v4n_pkg::out_word_t norm_word
);

	localparam int NC  = v4n_pkg::NUM_COMP;
	localparam int CW  = v4n_pkg::COMP_W;
	localparam int LW  = v4n_pkg::LEN_W;
	localparam int SW  = v4n_pkg::SUM_W;
	localparam int QW  = v4n_pkg::QUO_W;
	localparam int OF  = v4n_pkg::OUT_FRAC_BITS;
	localparam int UW  = v4n_pkg::UNIT_W;
	localparam int SRW = LW + 3;   // root remainder width with headroom
	localparam int DRW = LW + 1;   // divider remainder width

	// Shared advance: whole pipe moves unless the output word is held.
	logic adv;
	assign adv       = !(norm_valid && norm_stall);
	assign vec_stall = !adv;

	logic [CW-1:0] comp_in [NC];
	assign comp_in[0] = vec_word.comp_x;
	assign comp_in[1] = vec_word.comp_y;
	assign comp_in[2] = vec_word.comp_z;
	assign comp_in[3] = vec_word.comp_e;

	// Stage 1: sign and magnitude. -2^31 gives 2^31, which fits 32 bits.
	logic          v_s1;
	logic [CW-1:0] mag_s1 [NC];
	logic [NC-1:0] neg_s1;
	// Stage 2: squares.
	logic                      v_s2;
	logic [v4n_pkg::SQ_W-1:0]  sq_s2 [NC];
	logic [CW-1:0]             mag_s2 [NC];
	logic [NC-1:0]             neg_s2;
	// Stage 3: pair sums.
	logic          v_s3;
	logic [SW-1:0] pair_s3 [2];
	logic [CW-1:0] mag_s3 [NC];
	logic [NC-1:0] neg_s3;

	// Root pipe, index 0 fed by stage 4 (full sum).
	logic           rt_v    [0:LW];
	logic [SW-1:0]  rt_sum  [0:LW];
	logic [SRW-1:0] rt_rem  [0:LW];
	logic [LW-1:0]  rt_root [0:LW];
	logic [CW-1:0]  rt_mag  [0:LW][NC];
	logic [NC-1:0]  rt_neg  [0:LW];

	// Divider pipe, index 0 taken from the end of the root pipe.
	logic           dv_v   [0:QW];
	logic [LW-1:0]  dv_len [0:QW];
	logic [DRW-1:0] dv_rem [0:QW][NC];
	logic [QW-1:0]  dv_lo  [0:QW][NC];
	logic [QW-1:0]  dv_quo [0:QW][NC];
	logic [NC-1:0]  dv_neg [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			rt_v[0]  <= 1'b0;
		end else if (adv) begin
			v_s1     <= vec_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			rt_v[0]  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NC; i++) begin
				neg_s1[i] <= comp_in[i][CW-1];
				mag_s1[i] <= comp_in[i][CW-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				mag_s2[i] <= mag_s1[i];
				mag_s3[i] <= mag_s2[i];
				rt_mag[0][i] <= mag_s3[i];
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			rt_neg[0] <= neg_s3;
			pair_s3[0] <= SW'(sq_s2[0]) + SW'(sq_s2[1]);
			pair_s3[1] <= SW'(sq_s2[2]) + SW'(sq_s2[3]);
			rt_sum[0]  <= pair_s3[0] + pair_s3[1];
			rt_rem[0]  <= '0;
			rt_root[0] <= '0;
		end
	end

	// Restoring square root, two radicand bits and one root bit per stage.
	for (genvar k = 0; k < LW; k++) begin : g_root
		logic [SRW-1:0] trial_rem;
		logic [SRW-1:0] trial_sub;
		logic           fits;

		assign trial_rem = {rt_rem[k][SRW-3:0], rt_sum[k][SW-1:SW-2]};
		assign trial_sub = {1'b0, rt_root[k], 2'b01};
		assign fits      = trial_rem >= trial_sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else if (adv) begin
				rt_v[k+1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_sum[k+1]  <= {rt_sum[k][SW-3:0], 2'b00};
				rt_rem[k+1]  <= fits ? (trial_rem - trial_sub) : trial_rem;
				rt_root[k+1] <= {rt_root[k][LW-2:0], fits};
				rt_mag[k+1]  <= rt_mag[k];
				rt_neg[k+1]  <= rt_neg[k];
			end
		end
	end

	// Hand-off: magnitude never exceeds the truncated root, so mag>>1 < len.
	always_comb begin
		dv_v[0]   = rt_v[LW];
		dv_len[0] = rt_root[LW];
		dv_neg[0] = rt_neg[LW];
		for (int i = 0; i < NC; i++) begin
			dv_rem[0][i] = DRW'(rt_mag[LW][i][CW-1:1]);
			dv_lo[0][i]  = {rt_mag[LW][i][0], {OF{1'b0}}};
			dv_quo[0][i] = '0;
		end
	end

	// Restoring dividers, one quotient bit per stage for all four lanes.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DRW:0] part [NC];
		logic [NC-1:0] fits;

		always_comb begin
			for (int i = 0; i < NC; i++) begin
				part[i] = {dv_rem[j][i], dv_lo[j][i][QW-1]};
				fits[i] = part[i] >= (DRW+1)'(dv_len[j]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_len[j+1] <= dv_len[j];
				dv_neg[j+1] <= dv_neg[j];
				for (int i = 0; i < NC; i++) begin
					dv_rem[j+1][i] <= fits[i]
						? DRW'(part[i] - (DRW+1)'(dv_len[j])) : DRW'(part[i]);
					dv_lo[j+1][i]  <= {dv_lo[j][i][QW-2:0], 1'b0};
					dv_quo[j+1][i] <= {dv_quo[j][i][QW-2:0], fits[i]};
				end
			end
		end
	end

	// Output stage: clamp to one, apply sign, force zero for a zero length.
	localparam logic [QW-1:0] LIMIT = QW'(1) << OF;
	logic          len_zero;
	logic [UW-1:0] unit_nx [NC];

	assign len_zero = dv_len[QW] == '0;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			logic [QW-1:0] q;
			q = (dv_quo[QW][i] > LIMIT) ? LIMIT : dv_quo[QW][i];
			if (len_zero) begin
				unit_nx[i] = '0;
			end else if (dv_neg[QW][i]) begin
				unit_nx[i] = ~UW'(q) + 1'b1;
			end else begin
				unit_nx[i] = UW'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid <= 1'b0;
		end else if (adv) begin
			norm_valid <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_word.vec_length  <= dv_len[QW];
			norm_word.unit_x      <= unit_nx[0];
			norm_word.unit_y      <= unit_nx[1];
			norm_word.unit_z      <= unit_nx[2];
			norm_word.unit_e      <= unit_nx[3];
			norm_word.zero_length <= len_zero;
		end
	end

	// Zero flag must agree with the length it was derived from.
	a_zero_flag : assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |-> (norm_word.zero_length == (norm_word.vec_length == '0)))
		else $error("zero_length disagrees with vec_length");

	a_zero_units : assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm_word.zero_length |->
			norm_word.unit_x == '0 && norm_word.unit_y == '0 &&
			norm_word.unit_z == '0 && norm_word.unit_e == '0)
		else $error("nonzero unit component on zero-length word");

	a_unit_range : assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |->
			norm_word.unit_x <= $signed(UW'(LIMIT)) &&
			norm_word.unit_x >= -$signed(UW'(LIMIT)) &&
			norm_word.unit_e <= $signed(UW'(LIMIT)) &&
			norm_word.unit_e >= -$signed(UW'(LIMIT)))
		else $error("unit component beyond one");

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm_stall |=> $stable(dv_v[QW]) && $stable(rt_v[LW]))
		else $error("pipe moved while output held");

endmodule
